FILE: sv/gedd_pkg.sv
// ----------------------------------------------------------------------------
// gedd_pkg: shared types, constants and the share function
// Register indexes, quantization constants and share arithmetic for the
// gray error-diffusion dither.
// ----------------------------------------------------------------------------
package gedd_pkg;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned ERR_W     = 3;
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned IMG_W_W   = 11;
    localparam int unsigned IMG_H_W   = 12;
    localparam int unsigned ROW_W     = 11;
    localparam int unsigned MAX_ROWS  = 2048;

    localparam logic [11:0] RESET_WIDTH  = 12'd540;
    localparam logic [11:0] RESET_HEIGHT = 12'd960;

    localparam logic [PIX_W-1:0] QUANT_MASK = 8'hF0;
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [ERR_W-1:0] err_t;

    // Floyd-Steinberg share of a 4-bit error, truncated: (e * num) / 16
    function automatic err_t share(input logic [3:0] e, input logic [3:0] num);
        logic [7:0] prod;
        prod = 8'(e) * 8'(num);
        return err_t'(prod[7:4]);
    endfunction

endpackage

FILE: sv/gedd_line_buf.sv
// ----------------------------------------------------------------------------
// gedd_line_buf: error line buffer
// One write port and one registered read port holding the error that the
// current row passes to the row below.
// ----------------------------------------------------------------------------
module gedd_line_buf #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  gedd_pkg::err_t  wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output gedd_pkg::err_t  rdata
);
    import gedd_pkg::*;

    err_t mem [DEPTH];
    err_t rdata_reg;

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/gray_error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// gray_error_diffusion_dither: 16-level error-diffusion dither
// Raises each gray pixel by its diffused error (saturating), keeps the high
// nibble and spreads the low nibble 7/3/5/1 sixteenths to the neighbors.
//
//   channel  | signals                                  | dir
//   ---------+------------------------------------------+-----
//   input    | in_valid, in_ready, pixel_in             | in
//   output   | out_valid, out_ready, pixel_out,         | out
//            | row_end, frame_end                       |
//   config   | cfg_we, cfg_index, cfg_data              | in
//
// One pixel per cycle while the output is ready; the path runs from the input
// register to the output register, with the error math and line buffer update in between.
// The line buffer read is registered and issued when a beat is accepted.
// Reset clears counters, carries and valid flags and sets the default size;
// the line buffer needs no clearing as a frame's first row never uses it.
// A stalled output holds the output beat and the input register fills behind it.
// ----------------------------------------------------------------------------
module gray_error_diffusion_dither #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      pixel_out,
    output logic                            row_end,
    output logic                            frame_end,
    input  logic                            cfg_we,
    input  gedd_pkg::reg_index_t            cfg_index,
    input  logic [gedd_pkg::CFG_W-1:0]      cfg_data
);
    import gedd_pkg::*;

    localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned WCW = 13;

    // Configuration
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;

    // Position of the next pixel
    logic [CW-1:0]    col_cnt_reg;
    logic [ROW_W-1:0] row_cnt_reg;

    // Input stage
    logic             s0_valid_reg;
    pixel_t           s0_pixel_reg;
    logic [CW-1:0]    s0_col_reg;
    logic             s0_first_row_reg;
    logic             s0_last_col_reg;
    logic             s0_last_row_reg;

    // Error state
    err_t             right_carry_reg;
    err_t             part_left_reg;
    err_t             part_here_reg;

    // Deferred write of the last column entry
    logic             pend_valid_reg;
    logic [CW-1:0]    pend_addr_reg;
    err_t             pend_data_reg;

    // Bypass for writes landing after the line buffer read
    logic             byp_valid_reg;
    err_t             byp_data_reg;

    // Output register
    logic             out_valid_reg;
    pixel_t           pixel_out_reg;
    logic             row_end_reg;
    logic             frame_end_reg;

    logic             accept;
    logic             process;
    logic [WCW-1:0]   w_last;
    logic [IMG_H_W-1:0] h_last;
    logic             pos_last_col;
    logic             pos_last_row;
    logic             prim_we;
    logic             wr_en;
    logic [CW-1:0]    wr_addr;
    err_t             wr_data;
    err_t             rd_data;
    err_t             above;
    logic [8:0]       sum;
    pixel_t           sum_sat;
    logic [3:0]       err;
    err_t             s7;
    err_t             s3;
    err_t             s5;
    err_t             s1;
    err_t             new_left;
    err_t             prim_data;

    // Handshake
    assign process  = s0_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s0_valid_reg || process;
    assign accept   = in_valid && in_ready;

    // Last column and last row indexes with clamping
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_last = '0;
        end
        else if (WCW'(width_reg) > WCW'(MAX_WIDTH))
        begin
            w_last = WCW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = WCW'(width_reg) - WCW'(1);
        end

        if (height_reg == '0)
        begin
            h_last = '0;
        end
        else if (height_reg > IMG_H_W'(MAX_ROWS))
        begin
            h_last = IMG_H_W'(MAX_ROWS - 1);
        end
        else
        begin
            h_last = height_reg - IMG_H_W'(1);
        end
    end

    assign pos_last_col = WCW'(col_cnt_reg) >= w_last;
    assign pos_last_row = IMG_H_W'(row_cnt_reg) >= h_last;

    // Error arithmetic for the pixel in the input stage
    assign above   = s0_first_row_reg ? '0 :
                     (pend_valid_reg && pend_addr_reg == s0_col_reg) ? pend_data_reg :
                     byp_valid_reg ? byp_data_reg : rd_data;
    assign sum     = 9'(s0_pixel_reg) + 9'(right_carry_reg) + 9'(above);
    assign sum_sat = sum[8] ? PIX_MAX : sum[7:0];
    assign err     = sum_sat[3:0];
    assign s7      = share(err, 4'd7);
    assign s3      = share(err, 4'd3);
    assign s5      = share(err, 4'd5);
    assign s1      = share(err, 4'd1);
    assign new_left  = part_here_reg + s5;
    assign prim_data = part_left_reg + s3;

    // Line buffer write port: below-left share first, deferred entry otherwise
    assign prim_we = process && !s0_last_row_reg && (s0_col_reg != '0);
    assign wr_en   = prim_we || pend_valid_reg;
    assign wr_addr = prim_we ? (s0_col_reg - CW'(1)) : pend_addr_reg;
    assign wr_data = prim_we ? prim_data : pend_data_reg;

    gedd_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (col_cnt_reg),
        .rdata (rd_data)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMG_W_W'(RESET_WIDTH);
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[IMG_H_W-1:0];
                default:          ;
            endcase
        end
    end

    // Advance position and load the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s0_valid_reg <= 1'b1;
                if (pos_last_col)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= pos_last_row ? '0 : row_cnt_reg + ROW_W'(1);
                end
                else
                begin
                    col_cnt_reg <= col_cnt_reg + CW'(1);
                end
            end
            else if (process)
            begin
                s0_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_pixel_reg     <= pixel_in;
            s0_col_reg       <= col_cnt_reg;
            s0_first_row_reg <= (row_cnt_reg == '0);
            s0_last_col_reg  <= pos_last_col;
            s0_last_row_reg  <= pos_last_row;
        end
    end

    // Snoop writes that land after the line buffer read was issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            byp_valid_reg <= wr_en && (wr_addr == col_cnt_reg);
        end
        else if (s0_valid_reg && wr_en && (wr_addr == s0_col_reg))
        begin
            byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    // Update carries and the deferred entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_carry_reg <= '0;
            part_left_reg   <= '0;
            part_here_reg   <= '0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            if (process)
            begin
                right_carry_reg <= s0_last_col_reg ? '0 : s7;
                if (!s0_last_row_reg && !s0_last_col_reg)
                begin
                    part_left_reg <= new_left;
                    part_here_reg <= s1;
                end
                else
                begin
                    part_left_reg <= '0;
                    part_here_reg <= '0;
                end
            end

            if (process && !s0_last_row_reg && s0_last_col_reg)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_valid_reg && !prim_we)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && !s0_last_row_reg && s0_last_col_reg)
        begin
            pend_addr_reg <= s0_col_reg;
            pend_data_reg <= new_left;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            pixel_out_reg <= sum_sat & QUANT_MASK;
            row_end_reg   <= s0_last_col_reg;
            frame_end_reg <= s0_last_col_reg && s0_last_row_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

`ifndef ASSERT_OFF
    // A frame ends only on a row end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!frame_end || row_end))
        else $error("frame_end without row_end");

    // Result is quantized to 16 levels
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_out[3:0] == 4'd0))
        else $error("pixel_out low nibble not zero");

    // The deferred entry never competes with a below-left write
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !prim_we)
        else $error("line buffer write collision");

    // Column counter stays inside the line buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        WCW'(col_cnt_reg) < WCW'(MAX_WIDTH))
        else $error("column counter out of range");
`endif

endmodule

FILE: verif/tb_gray_error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// tb_gray_error_diffusion_dither: self-checking bench for the 16-level dither
// Streams gray pixels through the block with random gaps on both sides and
// occasional long output hold-offs. A scoreboard mirrors the error diffusion (right
// carry, partial sums for the row below, line of pending errors, row and
// column position) and compares every output beat in order. Frame sizes are
// changed between bursts, at frame starts and in the middle of rows.
// ----------------------------------------------------------------------------
module tb_gray_error_diffusion_dither;

    import gedd_pkg::*;

    localparam int unsigned LINE_DEPTH    = 1024;
    localparam int unsigned RANDOM_PIXELS = 1750;
    localparam int unsigned LONG_HOLD     = 64;
    localparam int unsigned DRAIN_CYCLES  = 8;

    typedef struct packed {
        pixel_t level;
        logic   row_last;
        logic   frame_last;
    } dither_beat_t;

    // Scoreboard: diffusion state, expected beats and the comparison
    class dither_scoreboard;
        logic [IMG_W_W-1:0] width_reg;
        logic [IMG_H_W-1:0] height_reg;
        bit [ERR_W-1:0]     err_line [LINE_DEPTH];
        bit                 line_written [LINE_DEPTH];
        bit [ERR_W-1:0]     carry_right;
        bit [ERR_W-1:0]     part_left;
        bit [ERR_W-1:0]     part_here;
        int unsigned        col;
        int unsigned        row;
        dither_beat_t       expected_q [$];
        int unsigned        mismatches;

        function new();
            width_reg   = RESET_WIDTH[IMG_W_W-1:0];
            height_reg  = RESET_HEIGHT[IMG_H_W-1:0];
            carry_right = '0;
            part_left   = '0;
            part_here   = '0;
            col         = 0;
            row         = 0;
            mismatches  = 0;
            foreach (line_written[i]) line_written[i] = 1'b0;
        endfunction

        function int unsigned eff_width(int unsigned v);
            if (v == 0) return 1;
            if (v > LINE_DEPTH) return LINE_DEPTH;
            return v;
        endfunction

        function int unsigned eff_height(int unsigned v);
            if (v == 0) return 1;
            if (v > MAX_ROWS) return MAX_ROWS;
            return v;
        endfunction

        function void write_reg(reg_index_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = data[IMG_H_W-1:0];
                default: ;
            endcase
        endfunction

        // A new width is safe when the next rows read only written line entries
        function bit width_safe(int unsigned v);
            if (row == 0) return 1'b1;
            for (int i = 0; i < eff_width(v); i++)
                if (!line_written[i]) return 1'b0;
            return 1'b1;
        endfunction

        // A new height may turn the current row into one that feeds a row below;
        // allow it only when every entry of the current width has been written
        function bit height_safe();
            for (int i = 0; i < eff_width(width_reg); i++)
                if (!line_written[i]) return 1'b0;
            return 1'b1;
        endfunction

        function bit at_frame_start();
            return col == 0 && row == 0;
        endfunction

        function int unsigned frame_remaining();
            int unsigned w;
            int unsigned h;
            int unsigned cols_left;
            int unsigned rows_after;
            w = eff_width(width_reg);
            h = eff_height(height_reg);
            cols_left  = (col >= w - 1) ? 1 : w - col;
            rows_after = (row >= h - 1) ? 0 : h - 1 - row;
            return cols_left + rows_after * w;
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        // Advance the diffusion by one accepted pixel and queue its beat
        function void note_pixel(pixel_t p);
            int unsigned  w;
            int unsigned  h;
            int unsigned  above;
            int unsigned  total;
            int unsigned  err;
            bit           last_col;
            bit           last_row;
            bit [ERR_W-1:0] below_left;
            dither_beat_t beat;
            w = eff_width(width_reg);
            h = eff_height(height_reg);
            last_col = col >= w - 1;
            last_row = row >= h - 1;

            // first row of a frame sees no error from above
            above = (row != 0) ? err_line[col] : 0;
            total = p + carry_right + above;
            if (total > 255) total = 255;
            err = total & 4'hF;

            carry_right = last_col ? '0 : ERR_W'(err * 7 / 16);

            // spread downward unless this is the last row
            if (!last_row) begin
                below_left = ERR_W'(part_here + err * 5 / 16);
                if (col > 0) begin
                    err_line[col-1]     = ERR_W'(part_left + err * 3 / 16);
                    line_written[col-1] = 1'b1;
                end
                if (last_col) begin
                    err_line[col]     = below_left;
                    line_written[col] = 1'b1;
                    part_left = '0;
                    part_here = '0;
                end
                else begin
                    part_left = below_left;
                    part_here = ERR_W'(err / 16);
                end
            end
            else begin
                part_left = '0;
                part_here = '0;
            end

            if (last_col) begin
                col = 0;
                row = last_row ? 0 : row + 1;
            end
            else begin
                col = col + 1;
            end

            beat.level      = pixel_t'(total & 8'hF0);
            beat.row_last   = last_col;
            beat.frame_last = last_col && last_row;
            expected_q.push_back(beat);
        endfunction

        // Compare one output beat with the oldest expectation
        function void check_beat(pixel_t level, logic row_last, logic frame_last);
            dither_beat_t beat;
            if (expected_q.size() == 0) begin
                $error("unexpected output beat: pixel_out=%0d", level);
                mismatches++;
                return;
            end
            beat = expected_q.pop_front();
            if (level !== beat.level) begin
                $error("pixel_out mismatch: expected %0d, got %0d", beat.level, level);
                mismatches++;
            end
            if (row_last !== beat.row_last) begin
                $error("row_end mismatch: expected %0b, got %0b", beat.row_last, row_last);
                mismatches++;
            end
            if (frame_last !== beat.frame_last) begin
                $error("frame_end mismatch: expected %0b, got %0b",
                       beat.frame_last, frame_last);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       pixel_in;
    logic             out_valid;
    logic             out_ready;
    logic [7:0]       pixel_out;
    logic             row_end;
    logic             frame_end;
    logic             cfg_we;
    reg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    dither_scoreboard board = new();
    bit               sender_dense;
    bit               receiver_dense;
    bit               long_hold;
    int unsigned      pixels_sent;

    gray_error_diffusion_dither DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .row_end   (row_end),
        .frame_end (frame_end),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bound the run in case the stream hangs
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic pixel_t random_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd255;
            1:       return 8'd0;
            2:       return {4'($urandom), 4'hF};
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one pixel after a random gap and hold it until accepted
    task automatic send_pixel(input pixel_t value);
        int unsigned gap;
        gap = sender_dense ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= value;
        do @(posedge clk); while (!in_ready);
        board.note_pixel(value);
        pixels_sent++;
    endtask

    // Drop valid and wait until every expected beat has come out
    task automatic wait_idle();
        if (in_valid)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        while (board.outstanding() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int unsigned value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.write_reg(idx, CFG_W'(value));
    endtask

    // Accept output beats after random stalls, with an occasional long hold
    initial
    begin : result_sink
        int unsigned stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = receiver_dense ? 0 : $urandom_range(0, 15);
            if (long_hold)
            begin
                stall     = LONG_HOLD;
                long_hold = 1'b0;
            end
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            board.check_beat(pixel_out, row_end, frame_end);
        end
    end

    initial
    begin : stimulus
        pixel_t      corner_frame [9];
        int unsigned n;
        int unsigned w;
        bit          cut;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        pixel_in       = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_IMAGE_WIDTH;
        cfg_data       = '0;
        sender_dense   = 1'b0;
        receiver_dense = 1'b0;
        long_hold      = 1'b0;
        pixels_sent    = 0;
        corner_frame   = '{8'd0, 8'd255, 8'd15, 8'd240, 8'd255, 8'd127,
                           8'd255, 8'd8, 8'd1};
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // 3x3 frame: zero and full error, saturation with error from above
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 3);
        foreach (corner_frame[i]) send_pixel(corner_frame[i]);

        // zero sizes act as one pixel per frame
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        send_pixel(8'd255);
        send_pixel(8'd0);

        // oversized registers saturate; shrink width mid-row, height mid-frame
        write_reg(REG_IMAGE_WIDTH, 2047);
        write_reg(REG_IMAGE_HEIGHT, 4095);
        send_pixel(8'd255);
        send_pixel(8'd17);
        send_pixel(8'd200);
        write_reg(REG_IMAGE_WIDTH, 2);
        repeat (5) send_pixel(random_pixel());
        write_reg(REG_IMAGE_HEIGHT, 2);
        repeat (2) send_pixel(random_pixel());

        // one full row at the widest size
        write_reg(REG_IMAGE_WIDTH, 2047);
        write_reg(REG_IMAGE_HEIGHT, 1);
        repeat (LINE_DEPTH) send_pixel(random_pixel());

        // random frames, small sizes, some cut short and resized mid-frame
        while (pixels_sent < RANDOM_PIXELS)
        begin
            sender_dense   = ($urandom_range(0, 3) == 0);
            receiver_dense = ($urandom_range(0, 3) == 0);
            if (board.at_frame_start())
            begin
                write_reg(REG_IMAGE_WIDTH, ($urandom_range(0, 7) == 0) ?
                          $urandom_range(17, 48) : $urandom_range(1, 12));
                write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 6));
            end
            n   = board.frame_remaining();
            cut = ($urandom_range(0, 4) == 0);
            if (cut) n = $urandom_range(1, n);
            if ($urandom_range(0, 11) == 0)
            begin
                long_hold    = 1'b1;
                sender_dense = 1'b1;
            end
            repeat (n) send_pixel(random_pixel());
            if (cut)
            begin
                w = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 16);
                if ($urandom_range(0, 1) == 0 && board.width_safe(w))
                    write_reg(REG_IMAGE_WIDTH, w);
                if ($urandom_range(0, 1) == 0 && board.height_safe())
                    write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 6));
            end
        end

        // let the pipeline empty, then report
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
